// ----- design/kths_pkg.sv -----
// ----------------------------------------------------------------------------
// kths_pkg
// types, constants and command structs shared by the track history store
// ----------------------------------------------------------------------------
`default_nettype none
package kths_pkg;
  localparam int MAX_TRACKS    = 16;
  localparam int HISTORY_DEPTH = 64;
  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int UW = $clog2(MAX_TRACKS + 1);
  localparam int AW = TW + SW;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_LATEST = 2'd1;
  localparam logic [1:0] FUNC_OLDEST = 2'd2;
  localparam logic [1:0] FUNC_PEEK   = 2'd3;

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_QUERY    = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        target_key;
    logic [47:0]        sample_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               sample_valid;
    logic [6:0]         sample_count;
    logic [47:0]        out_time;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_READ, S_DECIDE, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic read_issue;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/kths_ctrl.sv -----
// ----------------------------------------------------------------------------
// kths_ctrl
// sequencer: key search, slot read, decide and write, result strobe
// ----------------------------------------------------------------------------
`default_nettype none
module kths_ctrl import kths_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.scan_done) begin
          cmd.read_issue = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_READ: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(cmd.decide)) else $error("emit without decide");
  a_read_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_issue |-> sts.scan_done) else $error("read before scan done");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule
`default_nettype wire

// ----- design/kths_dp.sv -----
// ----------------------------------------------------------------------------
// kths_dp
// key table, ring pointers, history memory and result register
// ----------------------------------------------------------------------------
`default_nettype none
module kths_dp import kths_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  in_item_t   in_item,
  input  wire  [6:0] len_cfg,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_strobe,
  output out_item_t  out_item
);
  in_item_t item_r;
  logic [15:0] key_tab [MAX_TRACKS];
  logic [SW-1:0] head_r [MAX_TRACKS];
  logic [CW-1:0] fill_r [MAX_TRACKS];
  logic [CW-1:0] len_r  [MAX_TRACKS];
  logic [UW-1:0] used_r;
  logic [UW-1:0] scan_r;
  logic          found_r;
  logic [TW-1:0] tr_r;
  logic [AW-1:0] raddr_r;
  logic [47:0]   rtime_r;
  logic [191:0]  rvec_r;
  logic [47:0]   tmem [MAX_TRACKS*HISTORY_DEPTH];
  logic [191:0]  vmem [MAX_TRACKS*HISTORY_DEPTH];
  logic          strobe_r;
  out_item_t     out_r;
  out_item_t     out_nxt;

  logic [CW-1:0] eff_len;
  logic [SW-1:0] cur_head, latest_idx, oldest_idx;
  logic [CW-1:0] cur_fill, cur_len;
  logic [CW:0]   sum_l, sum_o;
  logic          is_push, new_track, full;
  logic          push_ok, older, same;

  assign sts.scan_done = (scan_r >= used_r) || found_r;

  always_comb begin
    if (len_cfg == 7'd0) eff_len = CW'(1);
    else if (32'(len_cfg) > HISTORY_DEPTH) eff_len = CW'(HISTORY_DEPTH);
    else eff_len = CW'(len_cfg);
  end

  assign is_push   = (item_r.func == FUNC_PUSH);
  assign new_track = !found_r;
  assign full      = (32'(used_r) >= MAX_TRACKS);
  assign cur_head  = found_r ? head_r[tr_r] : '0;
  assign cur_fill  = found_r ? fill_r[tr_r] : '0;
  assign cur_len   = found_r ? len_r[tr_r] : eff_len;
  assign sum_l = {1'b0, CW'(cur_head)} + {1'b0, cur_len} - (CW+1)'(1);
  assign sum_o = {1'b0, CW'(cur_head)} + {1'b0, cur_len} - {1'b0, cur_fill};
  assign latest_idx = SW'((sum_l >= {1'b0, cur_len}) ? sum_l - {1'b0, cur_len} : sum_l);
  assign oldest_idx = SW'((sum_o >= {1'b0, cur_len}) ? sum_o - {1'b0, cur_len} : sum_o);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.scan_start) begin
      scan_r <= '0;
      found_r <= 1'b0;
      tr_r <= '0;
    end else if (cmd.scan_step) begin
      if (key_tab[TW'(scan_r)] == item_r.target_key) begin
        found_r <= 1'b1;
        tr_r <= TW'(scan_r);
      end else begin
        scan_r <= scan_r + UW'(1);
      end
    end
    if (cmd.read_issue) begin
      raddr_r <= {(found_r ? tr_r : TW'(used_r)),
                  (item_r.func == FUNC_OLDEST) ? oldest_idx : latest_idx};
    end
    rtime_r <= tmem[raddr_r];
    rvec_r  <= vmem[raddr_r];
  end

  logic [TW-1:0] wtr;
  logic [SW-1:0] nhead;
  logic [191:0]  vin;
  assign wtr = found_r ? tr_r : TW'(used_r);
  assign nhead = (32'(cur_head) + 1 >= 32'(cur_len)) ? '0 : cur_head + SW'(1);
  assign vin = {item_r.pos_x, item_r.pos_y, item_r.pos_z,
                item_r.vel_x, item_r.vel_y, item_r.vel_z};

  assign push_ok = is_push && !(new_track && full);
  assign older   = (cur_fill != '0) && (item_r.sample_time < rtime_r);
  assign same    = (cur_fill != '0) && (item_r.sample_time == rtime_r);

  always_comb begin
    out_nxt = '0;
    if (is_push) begin
      if (new_track && full) begin
        out_nxt.status = ST_FULL;
      end else if (older) begin
        out_nxt.status = ST_DROPPED;
        out_nxt.sample_count = 7'(cur_fill);
      end else if (same) begin
        out_nxt.status = ST_REPLACED;
        out_nxt.sample_count = 7'(cur_fill);
      end else begin
        out_nxt.status = ST_APPENDED;
        out_nxt.sample_count = (cur_fill < cur_len) ? 7'(cur_fill + CW'(1)) : 7'(cur_fill);
      end
    end else begin
      out_nxt.status = ST_QUERY;
      if (found_r) begin
        out_nxt.sample_count = 7'(cur_fill);
        if (item_r.func != FUNC_PEEK && cur_fill != '0) begin
          out_nxt.sample_valid = 1'b1;
          out_nxt.out_time = rtime_r;
          {out_nxt.out_pos_x, out_nxt.out_pos_y, out_nxt.out_pos_z,
           out_nxt.out_vel_x, out_nxt.out_vel_y, out_nxt.out_vel_z} = rvec_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      used_r <= '0;
      for (int i = 0; i < MAX_TRACKS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
        len_r[i] <= '0;
      end
    end else begin
      strobe_r <= cmd.decide;
      if (cmd.decide) begin
        out_r <= out_nxt;
        if (push_ok && !older) begin
          if (same) begin
            vmem[raddr_r] <= vin;
          end else begin
            tmem[{wtr, cur_head}] <= item_r.sample_time;
            vmem[{wtr, cur_head}] <= vin;
            head_r[wtr] <= nhead;
            fill_r[wtr] <= (cur_fill < cur_len) ? cur_fill + CW'(1) : cur_fill;
            if (new_track) begin
              key_tab[wtr] <= item_r.target_key;
              len_r[wtr] <= eff_len;
              used_r <= used_r + UW'(1);
            end
          end
        end
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_item = out_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= MAX_TRACKS) else $error("track count overflow");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
  a_fill_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide && found_r |-> cur_fill <= cur_len) else $error("fill exceeds length");
`endif
endmodule
`default_nettype wire

// ----- design/keyed_track_history_store.sv -----
// sequence: serial key search over up to 16 stored keys, registered read of the
// history memory, decide and write, registered result strobe; a new item is not
// accepted while busy, which stays high through the result strobe
// reset: synchronous active low, clears track count and ring pointers
// length register resets to 64; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// keyed_track_history_store
// per key circular history store of timestamped samples
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_track_history_store import kths_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [6:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic [6:0] len_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= 7'd64;
    else if (cfg_valid) len_r <= cfg_data;
  end

  kths_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cmd(cmd), .sts(sts));
  kths_dp u_dp (.clk(clk), .rst_n(rst_n), .in_item(in_item), .len_cfg(len_r),
    .cmd(cmd), .sts(sts), .out_strobe(out_strobe), .out_item(out_item));
endmodule
`default_nettype wire
